### design/lht_pkg.sv
`timescale 1ns / 1ps

package lht_pkg;

    localparam int unsigned ID_W     = 4;
    localparam int unsigned MAX_IDS  = 16;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned HEALTH_W = 2;
    localparam int unsigned GEN_W    = 32;
    localparam int unsigned STAMP_W  = 64;
    localparam int unsigned MASK_W   = 16;

    localparam logic [CMD_W-1:0] CMD_BROKEN      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECOVERING  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HEALTHY     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOTE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_HEALTHY_GEN = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GET         = 3'd5;

    localparam logic [HEALTH_W-1:0] HEALTH_HEALTHY    = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_BROKEN     = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_RECOVERING = 2'd2;
    localparam logic [HEALTH_W-1:0] HEALTH_INVALID    = 2'd3;

    localparam logic [GEN_W-1:0] GEN_INIT = 32'd1;

    typedef struct packed {
        logic [HEALTH_W-1:0] health;
        logic [GEN_W-1:0]    generation;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    localparam t_entry ENTRY_INIT   = '{health: HEALTH_HEALTHY, generation: GEN_INIT,
                                        stamp: '0};
    localparam t_entry ENTRY_ABSENT = '{health: HEALTH_BROKEN, generation: '0,
                                        stamp: '0};

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ID_W-1:0]     plane_id;
        logic [HEALTH_W-1:0] remote_health;
        logic [GEN_W-1:0]    event_generation;
        logic [STAMP_W-1:0]  now_time;
    } t_req;

    typedef struct packed {
        logic   success;
        logic   applied;
        logic   snapshot_valid;
        t_entry entry;
    } t_result;

endpackage

### design/lht_cmd_if.sv
`timescale 1ns / 1ps

interface lht_cmd_if
    import lht_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [ID_W-1:0]     plane_id;
    logic [HEALTH_W-1:0] remote_health;
    logic [GEN_W-1:0]    event_generation;
    logic [STAMP_W-1:0]  now_time;

    modport source (
        output valid, command, plane_id, remote_health, event_generation, now_time,
        input  ready
    );
    modport sink (
        input  valid, command, plane_id, remote_health, event_generation, now_time,
        output ready
    );
endinterface

### design/lht_res_if.sv
`timescale 1ns / 1ps

interface lht_res_if
    import lht_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                success;
    logic                applied;
    logic                snapshot_valid;
    logic [HEALTH_W-1:0] entry_health;
    logic [GEN_W-1:0]    entry_generation;
    logic [STAMP_W-1:0]  entry_time;

    modport source (
        output valid, success, applied, snapshot_valid, entry_health,
               entry_generation, entry_time,
        input  ready
    );
    modport sink (
        input  valid, success, applied, snapshot_valid, entry_health,
               entry_generation, entry_time,
        output ready
    );
endinterface

### design/lht_table.sv
`timescale 1ns / 1ps

module lht_table
    import lht_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd_entry,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_entry
);

    logic [DEPTH-1:0] r_valid;
    t_entry           r_entries [DEPTH];

    // An entry that has not been written since the last clear reads as the initial entry.
    assign o_rd_entry = r_valid[i_rd_idx] ? r_entries[i_rd_idx] : ENTRY_INIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_entries[i_wr_idx] <= i_wr_entry;
        end
    end

endmodule

### design/lht_eval.sv
`timescale 1ns / 1ps

module lht_eval
    import lht_pkg::*;
(
    input  t_req    i_req,
    input  logic    i_present,
    input  t_entry  i_cur,
    output logic    o_we,
    output t_entry  o_next,
    output t_result o_result
);

    logic                ok;
    logic                applied;
    logic                snap;
    logic [HEALTH_W-1:0] want;

    always_comb begin
        ok      = 1'b0;
        applied = 1'b0;
        snap    = 1'b0;
        o_we    = 1'b0;
        o_next  = i_cur;
        want    = (i_req.command == CMD_BROKEN) ? HEALTH_BROKEN : HEALTH_RECOVERING;

        if (i_present) begin
            snap = 1'b1;
            case (i_req.command)
                CMD_BROKEN, CMD_RECOVERING: begin
                    ok = 1'b1;
                    // The generation only moves on a real change of health.
                    if (i_cur.health != want) begin
                        o_we              = 1'b1;
                        o_next.health     = want;
                        o_next.generation = i_cur.generation + GEN_W'(1);
                        o_next.stamp      = i_req.now_time;
                    end
                end
                CMD_HEALTHY: begin
                    ok            = 1'b1;
                    o_we          = 1'b1;
                    o_next.health = HEALTH_HEALTHY;
                    o_next.stamp  = i_req.now_time;
                end
                CMD_REMOTE: begin
                    if (i_req.event_generation == '0) begin
                        snap = 1'b0;
                    end else if (i_req.remote_health != HEALTH_INVALID) begin
                        ok = 1'b1;
                        // An equal generation never changes the entry, so only a
                        // newer generation is applied.
                        if (i_req.event_generation > i_cur.generation) begin
                            applied           = 1'b1;
                            o_we              = 1'b1;
                            o_next.health     = i_req.remote_health;
                            o_next.generation = i_req.event_generation;
                            o_next.stamp      = i_req.now_time;
                        end
                    end
                end
                CMD_HEALTHY_GEN: begin
                    if (i_cur.generation == i_req.event_generation
                        && i_cur.health != HEALTH_BROKEN
                        && i_cur.health != HEALTH_INVALID) begin
                        ok = 1'b1;
                        if (i_cur.health == HEALTH_RECOVERING) begin
                            o_we          = 1'b1;
                            o_next.health = HEALTH_HEALTHY;
                            o_next.stamp  = i_req.now_time;
                        end
                    end
                end
                CMD_GET: begin
                    ok = 1'b1;
                end
                default: begin
                    snap = 1'b0;
                end
            endcase
        end

        o_result.success        = ok;
        o_result.applied        = applied;
        o_result.snapshot_valid = snap;
        o_result.entry          = snap ? o_next : ENTRY_ABSENT;
    end

endmodule

### design/link_health_table.sv
`timescale 1ns / 1ps

// Channel     Direction  Transfer when          Payload
// i_cmd       in         valid && ready         command, plane_id, remote_health,
//                                               event_generation, now_time
// o_res       out        valid && ready         success, applied, snapshot_valid,
//                                               entry_health, entry_generation, entry_time
// i_cfg_*     in         i_cfg_we               plane_present_mask
//
// Each command passes through an input register and a result register, and its result
// is presented from the result register; a new command can be taken every cycle while
// the result register is free or its result transfers.
// The table is read and written between those two registers, so back-to-back commands
// to the same plane see each other's updates.
// Reset clears both stages, the mask and the table; a mask write reinitializes the table.
// A stalled result holds both stages; the input side stays ready while the input
// register is empty or the result moves on.

module link_health_table
    import lht_pkg::*;
#(
    parameter int unsigned NUM_PLANES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata,
    lht_cmd_if.sink           i_cmd,
    lht_res_if.source         o_res
);

    // Plane ids are four bits wide, so at most sixteen entries can ever be present.
    localparam int unsigned DEPTH = (NUM_PLANES < MAX_IDS) ? NUM_PLANES : MAX_IDS;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [MASK_W-1:0] r_mask;
    logic              r_in_valid;
    t_req              r_req;
    logic              r_out_valid;
    t_result           r_result;

    logic    advance;
    logic    present;
    t_entry  cur_entry;
    logic    eval_we;
    t_entry  next_entry;
    t_result eval_result;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign present     = ({1'b0, r_req.plane_id} < (ID_W + 1)'(DEPTH))
                         && r_mask[r_req.plane_id];

    lht_table #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (i_cfg_we),
        .i_rd_idx   (r_req.plane_id[IDX_W-1:0]),
        .o_rd_entry (cur_entry),
        .i_we       (advance && eval_we),
        .i_wr_idx   (r_req.plane_id[IDX_W-1:0]),
        .i_wr_entry (next_entry)
    );

    lht_eval u_eval (
        .i_req     (r_req),
        .i_present (present),
        .i_cur     (cur_entry),
        .o_we      (eval_we),
        .o_next    (next_entry),
        .o_result  (eval_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_req.command          <= i_cmd.command;
            r_req.plane_id         <= i_cmd.plane_id;
            r_req.remote_health    <= i_cmd.remote_health;
            r_req.event_generation <= i_cmd.event_generation;
            r_req.now_time         <= i_cmd.now_time;
        end
        if (advance) begin
            r_result <= eval_result;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.success          = r_result.success;
    assign o_res.applied          = r_result.applied;
    assign o_res.snapshot_valid   = r_result.snapshot_valid;
    assign o_res.entry_health     = r_result.entry.health;
    assign o_res.entry_generation = r_result.entry.generation;
    assign o_res.entry_time       = r_result.entry.stamp;

endmodule
